[rtl/cau_pkg.sv]
`default_nettype none

package cau_pkg;

    localparam int XW = 32;
    localparam int PW = 64;
    localparam int SW = PW + 2;
    localparam int RW = PW + 1;
    localparam int ITER_STEPS = 32;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_NEG   = 4'd4;
    localparam logic [3:0] OP_CONJ  = 4'd5;
    localparam logic [3:0] OP_MAGSQ = 4'd6;
    localparam logic [3:0] OP_MAG   = 4'd7;
    localparam logic [3:0] OP_EQUAL = 4'd8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [3:0]           req_type;
        logic signed [XW-1:0] a_re;
        logic signed [XW-1:0] a_im;
        logic signed [XW-1:0] b_re;
        logic signed [XW-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [XW-1:0] res_re;
        logic signed [XW-1:0] res_im;
        logic                 is_equal;
        logic [1:0]           status;
    } rsp_t;

    typedef struct packed {
        logic [3:0]    op;
        logic          live;
        rsp_t          pass;
        logic          neg_re;
        logic          neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [RW-1:0] rem_re;
        logic [RW-1:0] rem_im;
        logic [XW-1:0] low_re;
        logic [XW-1:0] low_im;
        logic [XW-1:0] quo_re;
        logic [XW-1:0] quo_im;
        logic [PW-1:0] den;
        logic [PW-1:0] sq_x;
        logic [PW-1:0] sq_res;
    } iter_t;

endpackage

`default_nettype wire

[rtl/cau_if.sv]
`default_nettype none

interface cau_req_if;
    import cau_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cau_rsp_if;
    import cau_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cau_iter_stage.sv]
`default_nettype none

module cau_iter_stage #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cau_pkg::iter_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cau_pkg::iter_t out_data
);
    import cau_pkg::*;

    localparam logic [PW-1:0] SQ_BIT = PW'(1) << (PW - 2 - 2 * STEP);

    logic          valid_reg;
    iter_t         data_reg;
    iter_t         data_next;
    logic [RW-1:0] rem_re_sh;
    logic [RW-1:0] rem_im_sh;
    logic [RW-1:0] den_ext;
    logic [PW-1:0] sq_trial;

    // One restoring quotient bit for each part and one root digit per stage.
    always_comb
    begin
        data_next = in_data;
        den_ext   = {1'b0, in_data.den};
        rem_re_sh = {in_data.rem_re[RW-2:0], in_data.low_re[XW-1]};
        rem_im_sh = {in_data.rem_im[RW-2:0], in_data.low_im[XW-1]};
        data_next.low_re = {in_data.low_re[XW-2:0], 1'b0};
        data_next.low_im = {in_data.low_im[XW-2:0], 1'b0};
        if (rem_re_sh >= den_ext)
        begin
            data_next.rem_re = rem_re_sh - den_ext;
            data_next.quo_re = {in_data.quo_re[XW-2:0], 1'b1};
        end
        else
        begin
            data_next.rem_re = rem_re_sh;
            data_next.quo_re = {in_data.quo_re[XW-2:0], 1'b0};
        end
        if (rem_im_sh >= den_ext)
        begin
            data_next.rem_im = rem_im_sh - den_ext;
            data_next.quo_im = {in_data.quo_im[XW-2:0], 1'b1};
        end
        else
        begin
            data_next.rem_im = rem_im_sh;
            data_next.quo_im = {in_data.quo_im[XW-2:0], 1'b0};
        end
        sq_trial = in_data.sq_res + SQ_BIT;
        if (in_data.sq_x >= sq_trial)
        begin
            data_next.sq_x   = in_data.sq_x - sq_trial;
            data_next.sq_res = (in_data.sq_res >> 1) + SQ_BIT;
        end
        else
        begin
            data_next.sq_res = in_data.sq_res >> 1;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/complex_arithmetic_unit_core.sv]
`default_nettype none

// Channel  Direction  Payload
// req      in         req_type, a_re, a_im, b_re, b_im
// rsp      out        res_re, res_im, is_equal, status
//
// One item is accepted per cycle while the pipeline has room; each item
// passes five front stages, 32 quotient and square-root stages and the output register.
// The restoring divider and root chain has 32 stages.
// Reset clears the valid bits only; payload registers are not reset.
// A stalled output holds the pipeline from the back; empty stages still fill.

module complex_arithmetic_unit_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    cau_req_if.sink   req,
    cau_rsp_if.source rsp
);
    import cau_pkg::*;

    localparam int EW = (DATA_WIDTH > XW) ? XW : DATA_WIDTH;
    localparam int FB = (FRAC_BITS > 30) ? 30 : FRAC_BITS;
    localparam int NW = PW + FB;
    localparam logic signed [SW-1:0] S_HI = (SW'(1) <<< (EW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] S_LO = -(SW'(1) <<< (EW - 1));
    localparam logic [PW-1:0] M_LIM = PW'(1) << (EW - 1);

    typedef struct packed {
        logic [XW-1:0] v;
        logic          s;
    } sat_t;

    typedef struct packed {
        logic [3:0]    op;
        rsp_t          pass;
        logic [XW-1:0] ma_re;
        logic [XW-1:0] ma_im;
        logic [XW-1:0] mb_re;
        logic [XW-1:0] mb_im;
        logic          na_re;
        logic          na_im;
        logic          nb_re;
        logic          nb_im;
    } s1_t;

    typedef struct packed {
        logic [3:0]    op;
        rsp_t          pass;
        logic [PW-1:0] p_rr;
        logic [PW-1:0] p_ii;
        logic [PW-1:0] p_ir;
        logic [PW-1:0] p_ri;
        logic [PW-1:0] p_br;
        logic [PW-1:0] p_bi;
        logic          n_rr;
        logic          n_ii;
        logic          n_ir;
        logic          n_ri;
    } s2_t;

    typedef struct packed {
        logic [3:0]           op;
        rsp_t                 pass;
        logic signed [SW-1:0] sum_a;
        logic signed [SW-1:0] sum_b;
        logic [PW-1:0]        den;
    } s3_t;

    typedef struct packed {
        logic [3:0]    op;
        logic          live;
        rsp_t          pass;
        logic [PW-1:0] num_a;
        logic [PW-1:0] num_b;
        logic [PW-1:0] den;
        logic          neg_a;
        logic          neg_b;
    } s4_t;

    function automatic logic signed [XW-1:0] sx(input logic [XW-1:0] v);
        return $signed(v << (XW - EW)) >>> (XW - EW);
    endfunction

    function automatic sat_t sat_s(input logic signed [SW-1:0] v);
        sat_t r;
        r.v = v[XW-1:0];
        r.s = 1'b0;
        if (v > S_HI)
        begin
            r.v = S_HI[XW-1:0];
            r.s = 1'b1;
        end
        else if (v < S_LO)
        begin
            r.v = S_LO[XW-1:0];
            r.s = 1'b1;
        end
        return r;
    endfunction

    function automatic sat_t sat_m(input logic neg, input logic [PW-1:0] mag);
        sat_t r;
        r.v = neg ? (XW'(0) - mag[XW-1:0]) : mag[XW-1:0];
        r.s = 1'b0;
        if (!neg && mag >= M_LIM)
        begin
            r.v = S_HI[XW-1:0];
            r.s = 1'b1;
        end
        else if (neg && mag > M_LIM)
        begin
            r.v = S_LO[XW-1:0];
            r.s = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] sv(input logic [PW-1:0] p, input logic n);
        logic signed [SW-1:0] t;
        t = $signed(SW'(p));
        return n ? -t : t;
    endfunction

    function automatic logic [XW-1:0] mag_of(input logic signed [XW-1:0] v);
        return v[XW-1] ? (XW'(0) - v) : v;
    endfunction

    // Pipeline handshake: a stage takes a new item when empty or moving on.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    s4_t   s4_reg, s4_next;
    iter_t s5_reg, s5_next;

    logic  it_valid [ITER_STEPS+1];
    logic  it_ready [ITER_STEPS+1];
    iter_t it_data  [ITER_STEPS+1];

    logic out_valid_reg;
    rsp_t out_data_reg, out_data_next;

    // Front stage: operand sign extension and the cheap operations.
    logic signed [XW-1:0] ar, ai, br, bi, mbr, mbi;
    sat_t t1_re, t1_im;

    always_comb
    begin
        ar = sx(req.data.a_re);
        ai = sx(req.data.a_im);
        br = sx(req.data.b_re);
        bi = sx(req.data.b_im);
        t1_re = '0;
        t1_im = '0;
        s1_next = '0;
        s1_next.op = req.data.req_type;
        case (req.data.req_type)
            OP_ADD:
            begin
                t1_re = sat_s(SW'(ar) + SW'(br));
                t1_im = sat_s(SW'(ai) + SW'(bi));
            end
            OP_SUB:
            begin
                t1_re = sat_s(SW'(ar) - SW'(br));
                t1_im = sat_s(SW'(ai) - SW'(bi));
            end
            OP_NEG:
            begin
                t1_re = sat_s(-SW'(ar));
                t1_im = sat_s(-SW'(ai));
            end
            OP_CONJ:
            begin
                t1_re.v = ar;
                t1_im = sat_s(-SW'(ai));
            end
            OP_EQUAL:
            begin
                s1_next.pass.is_equal = (ar == br) && (ai == bi);
            end
            default:
            begin
            end
        endcase
        s1_next.pass.res_re = t1_re.v;
        s1_next.pass.res_im = t1_im.v;
        s1_next.pass.status = (t1_re.s || t1_im.s) ? ST_SAT : ST_OK;
        // The magnitude operations square a by feeding it to both multiplier sides.
        if (req.data.req_type inside {OP_MAGSQ, OP_MAG})
        begin
            mbr = ar;
            mbi = ai;
        end
        else
        begin
            mbr = br;
            mbi = bi;
        end
        s1_next.ma_re = mag_of(ar);
        s1_next.ma_im = mag_of(ai);
        s1_next.mb_re = mag_of(mbr);
        s1_next.mb_im = mag_of(mbi);
        s1_next.na_re = ar[XW-1];
        s1_next.na_im = ai[XW-1];
        s1_next.nb_re = mbr[XW-1];
        s1_next.nb_im = mbi[XW-1];
    end

    always_comb
    begin
        s2_next.op   = s1_reg.op;
        s2_next.pass = s1_reg.pass;
        s2_next.p_rr = PW'(s1_reg.ma_re) * PW'(s1_reg.mb_re);
        s2_next.p_ii = PW'(s1_reg.ma_im) * PW'(s1_reg.mb_im);
        s2_next.p_ir = PW'(s1_reg.ma_im) * PW'(s1_reg.mb_re);
        s2_next.p_ri = PW'(s1_reg.ma_re) * PW'(s1_reg.mb_im);
        s2_next.p_br = PW'(s1_reg.mb_re) * PW'(s1_reg.mb_re);
        s2_next.p_bi = PW'(s1_reg.mb_im) * PW'(s1_reg.mb_im);
        s2_next.n_rr = s1_reg.na_re ^ s1_reg.nb_re;
        s2_next.n_ii = s1_reg.na_im ^ s1_reg.nb_im;
        s2_next.n_ir = s1_reg.na_im ^ s1_reg.nb_re;
        s2_next.n_ri = s1_reg.na_re ^ s1_reg.nb_im;
    end

    // Multiply subtracts the product of the imaginary parts; divide uses a times conj(b).
    always_comb
    begin
        s3_next.op    = s2_reg.op;
        s3_next.pass  = s2_reg.pass;
        s3_next.sum_a = sv(s2_reg.p_rr, s2_reg.n_rr)
                      + sv(s2_reg.p_ii, s2_reg.n_ii ^ (s2_reg.op == OP_MUL));
        s3_next.sum_b = sv(s2_reg.p_ir, s2_reg.n_ir)
                      + sv(s2_reg.p_ri, s2_reg.n_ri ^ (s2_reg.op != OP_MUL));
        s3_next.den   = s2_reg.p_br + s2_reg.p_bi;
    end

    logic signed [SW-1:0] sh_a, sh_b;
    sat_t t4_re, t4_im;

    always_comb
    begin
        sh_a = s3_reg.sum_a >>> FB;
        sh_b = s3_reg.sum_b >>> FB;
        t4_re = sat_s(sh_a);
        t4_im = sat_s(sh_b);
        s4_next.op    = s3_reg.op;
        s4_next.live  = 1'b0;
        s4_next.pass  = s3_reg.pass;
        s4_next.den   = s3_reg.den;
        s4_next.neg_a = s3_reg.sum_a[SW-1];
        s4_next.neg_b = s3_reg.sum_b[SW-1];
        s4_next.num_a = s3_reg.sum_a[SW-1] ? PW'(-s3_reg.sum_a) : PW'(s3_reg.sum_a);
        s4_next.num_b = s3_reg.sum_b[SW-1] ? PW'(-s3_reg.sum_b) : PW'(s3_reg.sum_b);
        case (s3_reg.op)
            OP_MUL:
            begin
                s4_next.pass.res_re = t4_re.v;
                s4_next.pass.res_im = t4_im.v;
                s4_next.pass.status = (t4_re.s || t4_im.s) ? ST_SAT : ST_OK;
            end
            OP_MAGSQ:
            begin
                s4_next.pass.res_re = t4_re.v;
                s4_next.pass.res_im = '0;
                s4_next.pass.status = t4_re.s ? ST_SAT : ST_OK;
            end
            OP_DIV:
            begin
                if (s3_reg.den == '0)
                begin
                    s4_next.pass.res_re = '0;
                    s4_next.pass.res_im = '0;
                    s4_next.pass.status = ST_DIV0;
                end
                else
                begin
                    s4_next.live = 1'b1;
                end
            end
            OP_MAG:
            begin
                s4_next.live = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Dividend is num * 2^FB; its bits from bit 32 up start the remainder, and a
    // start value not below the divisor means the quotient cannot fit.
    logic [NW-1:0] wide_a, wide_b, top_a, top_b;
    logic          ovf_a, ovf_b;

    always_comb
    begin
        wide_a = NW'(s4_reg.num_a) << FB;
        wide_b = NW'(s4_reg.num_b) << FB;
        top_a  = wide_a >> XW;
        top_b  = wide_b >> XW;
        ovf_a  = top_a >= NW'(s4_reg.den);
        ovf_b  = top_b >= NW'(s4_reg.den);
        s5_next.op     = s4_reg.op;
        s5_next.live   = s4_reg.live;
        s5_next.pass   = s4_reg.pass;
        s5_next.neg_re = s4_reg.neg_a;
        s5_next.neg_im = s4_reg.neg_b;
        s5_next.ovf_re = ovf_a;
        s5_next.ovf_im = ovf_b;
        s5_next.rem_re = ovf_a ? '0 : RW'(top_a);
        s5_next.rem_im = ovf_b ? '0 : RW'(top_b);
        s5_next.low_re = wide_a[XW-1:0];
        s5_next.low_im = wide_b[XW-1:0];
        s5_next.quo_re = '0;
        s5_next.quo_im = '0;
        s5_next.den    = s4_reg.den;
        s5_next.sq_x   = s4_reg.num_a;
        s5_next.sq_res = '0;
    end

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s5_ready = !s5_valid_reg || it_ready[0];
    assign req.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_reg <= s5_next;
        end
    end

    assign it_valid[0] = s5_valid_reg;
    assign it_data[0]  = s5_reg;

    for (genvar k = 0; k < ITER_STEPS; k++)
    begin : g_iter
        cau_iter_stage #(
            .STEP (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (it_valid[k]),
            .in_ready  (it_ready[k]),
            .in_data   (it_data[k]),
            .out_valid (it_valid[k+1]),
            .out_ready (it_ready[k+1]),
            .out_data  (it_data[k+1])
        );
    end

    assign it_ready[ITER_STEPS] = !out_valid_reg || rsp.ready;

    iter_t last;
    sat_t  tf_re, tf_im;

    always_comb
    begin
        last = it_data[ITER_STEPS];
        tf_re = sat_m(last.neg_re && (last.ovf_re || last.quo_re != '0),
                      last.ovf_re ? '1 : PW'(last.quo_re));
        tf_im = sat_m(last.neg_im && (last.ovf_im || last.quo_im != '0),
                      last.ovf_im ? '1 : PW'(last.quo_im));
        out_data_next = last.pass;
        if (last.live)
        begin
            if (last.op == OP_MAG)
            begin
                tf_re = sat_m(1'b0, last.sq_res);
                tf_im = '0;
            end
            out_data_next.res_re   = tf_re.v;
            out_data_next.res_im   = tf_im.v;
            out_data_next.is_equal = 1'b0;
            out_data_next.status   = (tf_re.s || tf_im.s) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (it_ready[ITER_STEPS])
        begin
            out_valid_reg <= it_valid[ITER_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (it_ready[ITER_STEPS] && it_valid[ITER_STEPS])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Input back-pressure only arises when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid && !rsp.ready)
        else $error("input blocked while the pipeline has room");

    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.status == ST_DIV0 |->
        rsp.data.res_re == '0 && rsp.data.res_im == '0 && !rsp.data.is_equal)
        else $error("divide-by-zero item carries a value");

    a_equal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.is_equal |->
        rsp.data.status == ST_OK && rsp.data.res_re == '0 && rsp.data.res_im == '0)
        else $error("equality item carries a value or a status");

endmodule

`default_nettype wire

[sim/complex_arithmetic_unit_core_tb.sv]
`default_nettype none

module complex_arithmetic_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    localparam int FRAC = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    logic clk;
    logic rst_n;

    cau_req_if req ();
    cau_rsp_if rsp ();

    complex_arithmetic_unit_core #(.DATA_WIDTH(32), .FRAC_BITS(FRAC)) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    rsp_t pending_q[$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    // Sign and magnitude of an intermediate value; 66 bits of magnitude are ample.
    typedef struct {
        bit         neg;
        logic [65:0] mag;
    } sm_t;

    function automatic sm_t sm_product(logic signed [31:0] x, logic signed [31:0] y);
        sm_t r;
        logic [65:0] ux;
        logic [65:0] uy;
        ux = x < 0 ? 66'(-64'(x)) : 66'(x);
        uy = y < 0 ? 66'(-64'(y)) : 66'(y);
        r.mag = ux * uy;
        r.neg = (r.mag != 0) && ((x < 0) != (y < 0));
        return r;
    endfunction

    function automatic sm_t sm_sum(sm_t a, sm_t b);
        sm_t r;
        if (a.neg == b.neg)
        begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end
        else if (a.mag >= b.mag)
        begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end
        else
        begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        if (r.mag == 0)
            r.neg = 0;
        return r;
    endfunction

    function automatic sm_t sm_flip(sm_t a);
        if (a.mag != 0)
            a.neg = !a.neg;
        return a;
    endfunction

    function automatic sm_t sm_floor(sm_t x);
        if (x.neg)
            x.mag = (x.mag + ((66'd1 << FRAC) - 1)) >> FRAC;
        else
            x.mag = x.mag >> FRAC;
        if (x.mag == 0)
            x.neg = 0;
        return x;
    endfunction

    // Scaled quotient truncated toward zero, clamped just beyond the range.
    // The scaled dividend needs more than 66 bits, so it is formed wider.
    function automatic sm_t sm_quot(sm_t num, logic [65:0] den);
        sm_t r;
        logic [65:0] q;
        logic [65:0] lim;
        logic [81:0] wq;
        lim = 66'd1 << 31;
        wq = (82'(num.mag) << FRAC) / 82'(den);
        if (wq > 82'(lim))
            wq = 82'(lim) + 82'd1;
        q = 66'(wq);
        r.mag = q;
        r.neg = num.neg && q != 0;
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_sm(sm_t x, ref bit sat);
        logic [65:0] lim;
        lim = 66'd1 << 31;
        if (!x.neg)
        begin
            if (x.mag >= lim)
            begin
                sat = 1;
                return MAXV;
            end
            return 32'(x.mag);
        end
        if (x.mag > lim)
        begin
            sat = 1;
            return MINV;
        end
        return 32'(-x.mag);
    endfunction

    function automatic logic signed [31:0] clamp_int(longint v, ref bit sat);
        if (v > longint'(MAXV))
        begin
            sat = 1;
            return MAXV;
        end
        if (v < longint'(MINV))
        begin
            sat = 1;
            return MINV;
        end
        return 32'(v);
    endfunction

    function automatic logic [65:0] int_sqrt(logic [65:0] x);
        logic [65:0] res;
        logic [65:0] bitv;
        res = 0;
        bitv = 66'd1 << 64;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic rsp_t complex_result(req_t r);
        rsp_t o;
        bit sat;
        sm_t den;
        sm_t s;
        longint ar;
        longint ai;
        longint br;
        longint bi;
        sat = 0;
        o = '0;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        case (r.req_type)
            OP_ADD:
            begin
                o.res_re = clamp_int(ar + br, sat);
                o.res_im = clamp_int(ai + bi, sat);
            end
            OP_SUB:
            begin
                o.res_re = clamp_int(ar - br, sat);
                o.res_im = clamp_int(ai - bi, sat);
            end
            OP_MUL:
            begin
                o.res_re = clamp_sm(sm_floor(sm_sum(sm_product(r.a_re, r.b_re),
                    sm_flip(sm_product(r.a_im, r.b_im)))), sat);
                o.res_im = clamp_sm(sm_floor(sm_sum(sm_product(r.a_im, r.b_re),
                    sm_product(r.a_re, r.b_im))), sat);
            end
            OP_DIV:
            begin
                den = sm_sum(sm_product(r.b_re, r.b_re), sm_product(r.b_im, r.b_im));
                if (den.mag == 0)
                    o.status = ST_DIV0;
                else
                begin
                    o.res_re = clamp_sm(sm_quot(sm_sum(sm_product(r.a_re, r.b_re),
                        sm_product(r.a_im, r.b_im)), den.mag), sat);
                    o.res_im = clamp_sm(sm_quot(sm_sum(sm_product(r.a_im, r.b_re),
                        sm_flip(sm_product(r.a_re, r.b_im))), den.mag), sat);
                end
            end
            OP_NEG:
            begin
                o.res_re = clamp_int(-ar, sat);
                o.res_im = clamp_int(-ai, sat);
            end
            OP_CONJ:
            begin
                o.res_re = r.a_re;
                o.res_im = clamp_int(-ai, sat);
            end
            OP_MAGSQ:
                o.res_re = clamp_sm(sm_floor(sm_sum(sm_product(r.a_re, r.a_re),
                    sm_product(r.a_im, r.a_im))), sat);
            OP_MAG:
            begin
                s = sm_sum(sm_product(r.a_re, r.a_re), sm_product(r.a_im, r.a_im));
                s.mag = int_sqrt(s.mag);
                o.res_re = clamp_sm(s, sat);
            end
            OP_EQUAL:
                o.is_equal = (r.a_re == r.b_re) && (r.a_im == r.b_im);
            default:
                ;
        endcase
        if (o.status == ST_OK && sat)
            o.status = ST_SAT;
        return o;
    endfunction

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t want;
    } row_t;

    row_t directed[$];

    function automatic req_t mk(logic [3:0] op, logic signed [31:0] ar,
        logic signed [31:0] ai, logic signed [31:0] br, logic signed [31:0] bi);
        req_t r;
        r.req_type = op;
        r.a_re = ar;
        r.a_im = ai;
        r.b_re = br;
        r.b_im = bi;
        return r;
    endfunction

    function automatic rsp_t rs(logic signed [31:0] re, logic signed [31:0] im,
        logic eq, logic [1:0] st);
        rsp_t o;
        o.res_re = re;
        o.res_im = im;
        o.is_equal = eq;
        o.status = st;
        return o;
    endfunction

    task automatic add_row(req_t r, bit typed, rsp_t want);
        row_t x;
        x.item = r;
        x.typed = typed;
        x.want = want;
        directed.push_back(x);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return MAXV;
            1: return MINV;
            2: return 32'($signed($urandom_range(0, 8'hff)) - 128) <<< FRAC;
            3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Checking and the receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result with none expected: %p", rsp.data);
                    errors++;
                end
                else
                begin
                    automatic rsp_t e = pending_q.pop_front();
                    if (rsp.data.res_re !== e.res_re)
                    begin
                        $error("res_re expected %0d got %0d", e.res_re, rsp.data.res_re);
                        errors++;
                    end
                    if (rsp.data.res_im !== e.res_im)
                    begin
                        $error("res_im expected %0d got %0d", e.res_im, rsp.data.res_im);
                        errors++;
                    end
                    if (rsp.data.is_equal !== e.is_equal)
                    begin
                        $error("is_equal expected %0d got %0d", e.is_equal,
                            rsp.data.is_equal);
                        errors++;
                    end
                    if (rsp.data.status !== e.status)
                    begin
                        $error("status expected %0d got %0d", e.status, rsp.data.status);
                        errors++;
                    end
                end
            end
            rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Valid is lowered only for the idle cycles in front of an item, so it is
    // never assigned twice in one time step.
    task automatic send(req_t r, bit typed, rsp_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.data <= r;
        do
            @(posedge clk);
        while (!req.ready);
        if (typed)
            pending_q.push_back(want);
        else
            pending_q.push_back(complex_result(r));
    endtask

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        req_t r;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            r.req_type = $urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
            r.a_re = rand_operand();
            r.a_im = rand_operand();
            r.b_re = rand_operand();
            r.b_im = rand_operand();
            case ($urandom_range(0, 9))
                0:
                begin
                    r.b_re = 0;
                    r.b_im = 0;
                end
                1:
                begin
                    r.b_re = r.a_re;
                    r.b_im = r.a_im;
                end
                2: r.b_im = 0;
                default:
                    ;
            endcase
            send(r, 0, '0);
        end
    endtask

    initial
    begin
        rst_n = 0;
        req.valid = 0;
        req.data = '0;
        add_row(mk(OP_ADD, 0, 0, 0, 0), 1, rs(0, 0, 0, ST_OK));
        add_row(mk(OP_ADD, MAXV, MINV, 1, -1), 1, rs(MAXV, MINV, 0, ST_SAT));
        add_row(mk(OP_SUB, MINV, MAXV, 1, -1), 1, rs(MINV, MAXV, 0, ST_SAT));
        add_row(mk(OP_SUB, 5, 7, 2, 3), 1, rs(3, 4, 0, ST_OK));
        add_row(mk(OP_MUL, 32'sh10000, 0, 32'sh20000, 0), 1, rs(32'sh20000, 0, 0, ST_OK));
        add_row(mk(OP_MUL, -1, 0, 1, 0), 1, rs(-1, 0, 0, ST_OK));
        add_row(mk(OP_MUL, MAXV, MAXV, MAXV, MINV), 0, '0);
        add_row(mk(OP_MUL, 32'sh30000, -32'sh18000, 32'sh8000, 32'sh50000), 0, '0);
        add_row(mk(OP_DIV, 5, 5, 0, 0), 1, rs(0, 0, 0, ST_DIV0));
        add_row(mk(OP_DIV, 32'sh40000, 0, 32'sh20000, 0), 1, rs(32'sh20000, 0, 0, ST_OK));
        add_row(mk(OP_DIV, MAXV, MINV, 1, 0), 1, rs(MAXV, MINV, 0, ST_SAT));
        add_row(mk(OP_DIV, -7, 3, 32'sh30000, -32'sh10000), 0, '0);
        add_row(mk(OP_DIV, MINV, MINV, MINV, MAXV), 0, '0);
        add_row(mk(OP_NEG, MINV, 5, 9, 9), 1, rs(MAXV, -5, 0, ST_SAT));
        add_row(mk(OP_NEG, MAXV, 0, 0, 0), 1, rs(MINV + 1, 0, 0, ST_OK));
        add_row(mk(OP_CONJ, MINV, MINV, 3, 3), 1, rs(MINV, MAXV, 0, ST_SAT));
        add_row(mk(OP_CONJ, 7, -7, 0, 0), 1, rs(7, 7, 0, ST_OK));
        add_row(mk(OP_MAGSQ, 32'sh30000, 32'sh40000, 1, 1), 1, rs(32'sh190000, 0, 0, ST_OK));
        add_row(mk(OP_MAGSQ, MINV, MINV, 0, 0), 1, rs(MAXV, 0, 0, ST_SAT));
        add_row(mk(OP_MAG, 3, 4, 8, 8), 1, rs(5, 0, 0, ST_OK));
        add_row(mk(OP_MAG, MINV, MINV, 0, 0), 1, rs(MAXV, 0, 0, ST_SAT));
        add_row(mk(OP_EQUAL, MAXV, MINV, MAXV, MINV), 1, rs(0, 0, 1, ST_OK));
        add_row(mk(OP_EQUAL, 1, 2, 1, 3), 1, rs(0, 0, 0, ST_OK));
        add_row(mk(4'd9, 1, 2, 3, 4), 1, rs(0, 0, 0, ST_OK));
        add_row(mk(4'd15, MAXV, MAXV, MAXV, MAXV), 1, rs(0, 0, 0, ST_OK));
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (directed[i])
            send(directed[i].item, directed[i].typed, directed[i].want);
        random_phase(110, 0, 0);
        random_phase(100, 82, 0);
        random_phase(100, 0, 82);
        random_phase(100, 35, 35);
        random_phase(40, 0, 0);
        req.valid <= 0;
        recv_stall_pct = 0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire
